// ===== hw/rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, constants and helpers for the stream pattern replace block.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int MAX_PATTERN_BYTES     = 8;
  localparam int MAX_REPLACEMENT_BYTES = 8;
  localparam int BYTE_W                = 8;
  localparam int WORD_W                = 64;
  localparam int LEN_W                 = 4;
  localparam int CFG_INDEX_W           = 2;
  localparam int QUEUE_DEPTH           = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } reg_index_t;

  // One request from the front to the back: up to eight bytes to emit.
  typedef struct packed {
    logic [WORD_W-1:0] bytes;
    logic [LEN_W-1:0]  count;      // 1..8
    logic              no_data;
    logic              stream_end;
  } cmd_t;

  function automatic logic [LEN_W-1:0] eff_plen(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] p;
    p = len;
    if (p == '0) p = LEN_W'(1);
    if (p > LEN_W'(MAX_PATTERN_BYTES)) p = LEN_W'(MAX_PATTERN_BYTES);
    return p;
  endfunction

  function automatic logic [LEN_W-1:0] eff_rlen(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    r = len;
    if (r > LEN_W'(MAX_REPLACEMENT_BYTES)) r = LEN_W'(MAX_REPLACEMENT_BYTES);
    return r;
  endfunction

endpackage

// ===== hw/rtl/spr_front.sv =====
// ----------------------------------------------------------------------------
// spr_front
// Holds the configuration and the window, compares and turns each input
// byte into at most one emit request for the back end.
// ----------------------------------------------------------------------------
module spr_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [spr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [spr_pkg::WORD_W-1:0]         cfg_data,
  input  logic                               in_valid,
  input  logic                               q_full,
  input  logic [spr_pkg::BYTE_W-1:0]         in_byte,
  input  logic                               stream_end,
  output logic                               push,
  output spr_pkg::cmd_t                      cmd
);

  logic [spr_pkg::WORD_W-1:0] pattern_bytes;
  logic [spr_pkg::LEN_W-1:0]  pattern_length;
  logic [spr_pkg::WORD_W-1:0] replacement_bytes;
  logic [spr_pkg::LEN_W-1:0]  replacement_length;
  logic [spr_pkg::LEN_W-1:0]  count;
  logic [spr_pkg::LEN_W-1:0]  count_next;
  logic [spr_pkg::BYTE_W-1:0] win [spr_pkg::MAX_PATTERN_BYTES];
  logic [spr_pkg::BYTE_W-1:0] win_next [spr_pkg::MAX_PATTERN_BYTES];
  logic [spr_pkg::BYTE_W-1:0] win_ins [spr_pkg::MAX_PATTERN_BYTES];
  logic [spr_pkg::WORD_W-1:0] win_word;
  logic [spr_pkg::LEN_W-1:0]  plen;
  logic [spr_pkg::LEN_W-1:0]  rlen;
  logic [spr_pkg::LEN_W-1:0]  cnt1;
  logic [spr_pkg::LEN_W-1:0]  n;
  logic                       accept;
  logic                       cmp;
  logic                       match;
  logic                       hit;

  assign accept = in_valid && !q_full;

  always_comb begin
    plen  = spr_pkg::eff_plen(pattern_length);
    rlen  = spr_pkg::eff_rlen(replacement_length);
    cnt1  = count + spr_pkg::LEN_W'(1);
    cmp   = (cnt1 == plen);
    match = 1'b1;
    for (int i = 0; i < spr_pkg::MAX_PATTERN_BYTES; i++) begin
      win_ins[i] = (count == spr_pkg::LEN_W'(i)) ? in_byte : win[i];
      win_word[spr_pkg::BYTE_W*i +: spr_pkg::BYTE_W] = win_ins[i];
      if (spr_pkg::LEN_W'(i) < plen &&
          win_ins[i] != pattern_bytes[spr_pkg::BYTE_W*i +: spr_pkg::BYTE_W]) begin
        match = 1'b0;
      end
    end
    hit = cmp && match;

    // next window: emptied on hit or end, slid by one on a mismatch
    for (int i = 0; i < spr_pkg::MAX_PATTERN_BYTES - 1; i++) begin
      if (cmp && !hit) begin
        win_next[i] = win_ins[i+1];
      end else begin
        win_next[i] = win_ins[i];
      end
    end
    win_next[spr_pkg::MAX_PATTERN_BYTES-1] = win_ins[spr_pkg::MAX_PATTERN_BYTES-1];
    if (hit || stream_end) begin
      count_next = '0;
    end else if (cmp) begin
      count_next = count;
    end else begin
      count_next = cnt1;
    end

    if (hit) begin
      n         = rlen;
      cmd.bytes = replacement_bytes;
    end else if (stream_end) begin
      n         = cnt1;
      cmd.bytes = win_word;
    end else begin
      n         = cmp ? spr_pkg::LEN_W'(1) : '0;
      cmd.bytes = win_word;
    end
    cmd.stream_end = stream_end;
    cmd.no_data    = 1'b0;
    cmd.count      = n;
    if (n == '0) begin
      // end with nothing emitted: a lone end marker
      cmd.no_data = 1'b1;
      cmd.count   = spr_pkg::LEN_W'(1);
      cmd.bytes   = '0;
    end
    push = accept && (n != '0 || stream_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= spr_pkg::LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
      count              <= '0;
    end else if (cfg_write) begin
      case (spr_pkg::reg_index_t'(cfg_index))
        spr_pkg::REG_PATTERN_BYTES: begin
          pattern_bytes <= cfg_data;
        end
        spr_pkg::REG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[spr_pkg::LEN_W-1:0];
          count          <= '0;
        end
        spr_pkg::REG_REPLACEMENT_BYTES: begin
          replacement_bytes <= cfg_data;
        end
        spr_pkg::REG_REPLACEMENT_LENGTH: begin
          replacement_length <= cfg_data[spr_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < spr_pkg::MAX_PATTERN_BYTES; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule

// ===== hw/rtl/spr_queue.sv =====
// ----------------------------------------------------------------------------
// spr_queue
// Two-entry request queue between the front and the back end.
// ----------------------------------------------------------------------------
module spr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output spr_pkg::cmd_t head
);

  spr_pkg::cmd_t slots [spr_pkg::QUEUE_DEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full       = (fill == 2'(spr_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

// ===== hw/rtl/spr_back.sv =====
// ----------------------------------------------------------------------------
// spr_back
// Walks the head request one byte per cycle into the output register while out_stall is low.
// ----------------------------------------------------------------------------
module spr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  spr_pkg::cmd_t              head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [spr_pkg::BYTE_W-1:0] out_byte,
  output logic                       no_data,
  output logic                       last_of_item,
  output logic                       end_of_output
);

  logic [2:0] idx;
  logic       load;
  logic       last;

  assign load = !out_valid || !out_stall;
  assign last = ({1'b0, idx} + spr_pkg::LEN_W'(1)) == head.count;
  assign pop  = load && head_valid && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte      <= head.bytes[{idx, 3'b000} +: spr_pkg::BYTE_W];
      no_data       <= head.no_data;
      last_of_item  <= last;
      end_of_output <= last && head.stream_end;
    end
  end

endmodule

// ===== hw/rtl/stream_pattern_replace_top.sv =====
// Path: an accepted byte's request is written into the queue, then moved from its head into the output register.
// Throughput: one input byte per cycle and one result per cycle while out_stall
// is low; a request holds the back end until its last result byte is out, and
// input stalls once the two-entry queue between front and back is full.
// Reset: configuration returns to its defaults, window empty, queue and
// output register empty. No clearing pass.
// ----------------------------------------------------------------------------
// stream_pattern_replace_top
// Streaming find-and-replace on a byte stream with a window of up to 8 bytes.
// ----------------------------------------------------------------------------
module stream_pattern_replace_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [spr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spr_pkg::WORD_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [spr_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            stream_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spr_pkg::BYTE_W-1:0]      out_byte,
  output logic                            no_data,
  output logic                            last_of_item,
  output logic                            end_of_output
);

  logic          q_full;
  logic          push;
  logic          pop;
  logic          head_valid;
  spr_pkg::cmd_t push_cmd;
  spr_pkg::cmd_t head;

  assign in_stall = q_full;

  spr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .q_full     (q_full),
    .in_byte    (in_byte),
    .stream_end (stream_end),
    .push       (push),
    .cmd        (push_cmd)
  );

  spr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  spr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .no_data       (no_data),
    .last_of_item  (last_of_item),
    .end_of_output (end_of_output)
  );

endmodule

// ===== hw/rtl/spr_checker.sv =====
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks on the result stream of the top level.
// ----------------------------------------------------------------------------
module spr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [spr_pkg::BYTE_W-1:0] out_byte,
  input logic                       no_data,
  input logic                       last_of_item,
  input logic                       end_of_output
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(end_of_output))
    else $error("stalled result changed");

  // a bare end marker closes both the item and the stream
  a_nodata_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_data |-> last_of_item && end_of_output)
    else $error("end marker without last flags");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_output |-> last_of_item)
    else $error("end of output not last of item");

  a_nodata_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_data |-> out_byte == '0)
    else $error("end marker carries a byte");

endmodule

bind stream_pattern_replace_top spr_checker u_spr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .no_data       (no_data),
  .last_of_item  (last_of_item),
  .end_of_output (end_of_output)
);

// ===== test/stream_pattern_replace_top_tb.sv =====
// ----------------------------------------------------------------------------
// stream_pattern_replace_top_tb
// Self-checking bench for the streaming find-and-replace block: a directed
// table of corner cases, then random streams built around the configured
// pattern, with random sender gaps and receiver stalls, checked against a
// local byte-window predictor.
// ----------------------------------------------------------------------------
module stream_pattern_replace_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [spr_pkg::BYTE_W-1:0] val;
    logic                       nd;
    logic                       lst;
    logic                       eoo;
  } out_rec_t;

  // One row of the directed table: a register write or an input byte.
  typedef struct {
    bit                         is_cfg;
    spr_pkg::reg_index_t        idx;
    logic [spr_pkg::WORD_W-1:0] data;
    logic [spr_pkg::BYTE_W-1:0] val;
    bit                         fin;
    bit                         typed;   // expected result given in the row itself
    int                         t_n;     // 0 or 1 results
    logic [spr_pkg::BYTE_W-1:0] t_val;
    bit                         t_nd;
  } plan_row_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  spr_pkg::reg_index_t        cfg_index = spr_pkg::REG_PATTERN_BYTES;
  logic [spr_pkg::WORD_W-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [spr_pkg::BYTE_W-1:0] in_byte = '0;
  logic                       stream_end = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [spr_pkg::BYTE_W-1:0] out_byte;
  logic                       no_data;
  logic                       last_of_item;
  logic                       end_of_output;

  // predictor state
  logic [spr_pkg::WORD_W-1:0] pat_word = '0;
  logic [spr_pkg::LEN_W-1:0]  pat_len = 4'd1;
  logic [spr_pkg::WORD_W-1:0] rep_word = '0;
  logic [spr_pkg::LEN_W-1:0]  rep_len = '0;
  logic [spr_pkg::BYTE_W-1:0] win_bytes [8];
  int unsigned                win_fill = 0;

  out_rec_t                   step_bytes [9];
  int                         step_n;
  out_rec_t                   pending_out_bytes [$];

  int                         err_cnt = 0;
  int                         bytes_sent = 0;
  int                         streams_done = 0;
  int                         regs_written = 0;
  int                         results_seen = 0;
  bit                         idle_on = 1'b1;
  int                         hold_asked = 0;
  int                         hold_served = 0;

  stream_pattern_replace_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .stream_end    (stream_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .no_data       (no_data),
    .last_of_item  (last_of_item),
    .end_of_output (end_of_output)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("stream_pattern_replace_top test failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic void add_out(input logic [spr_pkg::BYTE_W-1:0] b, input logic nd);
    step_bytes[step_n] = '{val: b, nd: nd, lst: 1'b0, eoo: 1'b0};
    step_n++;
  endfunction

  // Output bytes caused by one input byte; updates the window.
  function automatic void predict_stream_bytes(input logic [spr_pkg::BYTE_W-1:0] b,
                                              input logic fin);
    int  plen;
    int  rlen;
    bit  hit;
    step_n = 0;
    plen = (pat_len == 0) ? 1 :
           ((pat_len > spr_pkg::MAX_PATTERN_BYTES) ? spr_pkg::MAX_PATTERN_BYTES
                                                   : int'(pat_len));
    rlen = (rep_len > spr_pkg::MAX_REPLACEMENT_BYTES) ? spr_pkg::MAX_REPLACEMENT_BYTES
                                                      : int'(rep_len);
    if (win_fill < 8) begin
      win_bytes[win_fill] = b;
      win_fill++;
    end
    if (win_fill >= plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (win_bytes[i] != pat_word[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < rlen; i++) add_out(rep_word[8*i +: 8], 1'b0);
        win_fill = 0;
      end else begin
        add_out(win_bytes[0], 1'b0);
        for (int i = 1; i < win_fill; i++) win_bytes[i-1] = win_bytes[i];
        win_fill--;
      end
    end
    if (fin) begin
      for (int i = 0; i < win_fill; i++) add_out(win_bytes[i], 1'b0);
      win_fill = 0;
      if (step_n == 0) add_out('0, 1'b1);
    end
    if (step_n > 0) begin
      step_bytes[step_n-1].lst = 1'b1;
      step_bytes[step_n-1].eoo = fin;
    end
  endfunction

  // Leaves cfg_write high; the next drain or send lowers it.
  task automatic write_reg(input spr_pkg::reg_index_t idx,
                           input logic [spr_pkg::WORD_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    regs_written++;
    case (idx)
      spr_pkg::REG_PATTERN_BYTES:      pat_word = d;
      spr_pkg::REG_PATTERN_LENGTH: begin
        pat_len  = d[spr_pkg::LEN_W-1:0];
        win_fill = 0;
      end
      spr_pkg::REG_REPLACEMENT_BYTES:  rep_word = d;
      spr_pkg::REG_REPLACEMENT_LENGTH: rep_len = d[spr_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid  <= 1'b0;
    cfg_write <= 1'b0;
    while (pending_out_bytes.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Offers one byte, returns at the accepting edge with the prediction made.
  task automatic send_byte(input logic [spr_pkg::BYTE_W-1:0] b, input logic fin);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    cfg_write <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    stream_end <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (fin) streams_done++;
    predict_stream_bytes(b, fin);
  endtask

  task automatic queue_predicted();
    for (int i = 0; i < step_n; i++) pending_out_bytes.push_back(step_bytes[i]);
  endtask

  function automatic plan_row_t mk_cfg(input spr_pkg::reg_index_t idx,
                                       input logic [spr_pkg::WORD_W-1:0] d);
    plan_row_t r;
    r = '{idx: spr_pkg::REG_PATTERN_BYTES, default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = d;
    return r;
  endfunction

  function automatic plan_row_t mk_byte(input logic [spr_pkg::BYTE_W-1:0] b, input bit fin);
    plan_row_t r;
    r = '{idx: spr_pkg::REG_PATTERN_BYTES, default: '0};
    r.val = b;
    r.fin = fin;
    return r;
  endfunction

  function automatic plan_row_t mk_known(input logic [spr_pkg::BYTE_W-1:0] b, input bit fin,
                                         input int n, input logic [spr_pkg::BYTE_W-1:0] ev,
                                         input bit nd);
    plan_row_t r;
    r = mk_byte(b, fin);
    r.typed = 1'b1;
    r.t_n   = n;
    r.t_val = ev;
    r.t_nd  = nd;
    return r;
  endfunction

  // receiver: per-result stall draw, plus one long hold-off on request
  initial begin : rx_side
    int w;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        w = idle_on ? $urandom_range(0, 13) : 0;
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_out_bytes.size() == 0) begin
        report_mismatch($sformatf("output byte %02h with nothing pending", out_byte));
      end else begin
        want = pending_out_bytes.pop_front();
        if (want.nd !== no_data || (!want.nd && want.val !== out_byte) ||
            want.lst !== last_of_item || want.eoo !== end_of_output) begin
          report_mismatch($sformatf(
            "got byte %02h nd %b last %b end %b, want byte %02h nd %b last %b end %b",
            out_byte, no_data, last_of_item, end_of_output,
            want.val, want.nd, want.lst, want.eoo));
        end
      end
    end
  end

  initial begin : stim
    plan_row_t                  plan [$];
    out_rec_t                   t;
    logic [spr_pkg::BYTE_W-1:0] alpha [3];
    logic [spr_pkg::BYTE_W-1:0] chunk [8];
    logic [spr_pkg::WORD_W-1:0] pw;
    int                         pl;
    int                         pe;
    int                         rl;
    int                         n;
    int                         k;
    int                         clen;
    int                         sel;
    bit                         fin;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset: pattern 00, length 1, empty replacement
    plan.push_back(mk_known(8'h00, 0, 0, 8'h00, 0));
    plan.push_back(mk_known(8'hFF, 0, 1, 8'hFF, 0));
    plan.push_back(mk_known(8'h00, 1, 1, 8'h00, 1));   // end, nothing emitted
    plan.push_back(mk_known(8'hA5, 1, 1, 8'hA5, 0));
    // "ab" -> "XYZ"
    plan.push_back(mk_cfg(spr_pkg::REG_PATTERN_BYTES, 64'h6261));
    plan.push_back(mk_cfg(spr_pkg::REG_PATTERN_LENGTH, 64'd2));
    plan.push_back(mk_cfg(spr_pkg::REG_REPLACEMENT_BYTES, 64'h5A5958));
    plan.push_back(mk_cfg(spr_pkg::REG_REPLACEMENT_LENGTH, 64'd3));
    plan.push_back(mk_byte(8'h61, 0));
    plan.push_back(mk_byte(8'h62, 0));
    plan.push_back(mk_byte(8'h61, 0));
    plan.push_back(mk_byte(8'h61, 0));
    plan.push_back(mk_byte(8'h62, 0));
    plan.push_back(mk_byte(8'h63, 1));
    // length field zero counts as one; upper data bits are junk
    plan.push_back(mk_cfg(spr_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0));
    plan.push_back(mk_cfg(spr_pkg::REG_PATTERN_BYTES, 64'h41));
    plan.push_back(mk_cfg(spr_pkg::REG_REPLACEMENT_LENGTH, 64'd0));
    plan.push_back(mk_known(8'h41, 0, 0, 8'h00, 0));
    plan.push_back(mk_known(8'h41, 1, 1, 8'h00, 1));
    // saturated lengths: 15 -> 8 on both sides
    plan.push_back(mk_cfg(spr_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(mk_cfg(spr_pkg::REG_PATTERN_LENGTH, 64'd15));
    plan.push_back(mk_cfg(spr_pkg::REG_REPLACEMENT_BYTES, 64'h0011_2233_4455_6677));
    plan.push_back(mk_cfg(spr_pkg::REG_REPLACEMENT_LENGTH, 64'hFFFF_FFFF_0000_000F));
    for (int i = 0; i < 8; i++) plan.push_back(mk_byte(8'hFF, 0));
    plan.push_back(mk_byte(8'hFF, 0));
    plan.push_back(mk_byte(8'h00, 1));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_byte(plan[i].val, plan[i].fin);
        if (plan[i].typed) begin
          t = '{val: plan[i].t_val, nd: plan[i].t_nd, lst: 1'b1, eoo: plan[i].fin};
          if (plan[i].t_n == 1) pending_out_bytes.push_back(t);
        end else begin
          queue_predicted();
        end
      end
    end

    // random phases: streams built from a small alphabet around the pattern
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      idle_on = (ph != 0 && ph != 2);
      foreach (alpha[j]) alpha[j] = 8'($urandom_range(0, 255));
      case (ph)
        1:       pl = 8;
        3:       pl = 1;
        5:       pl = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
        default: pl = $urandom_range(1, 8);
      endcase
      pe = (pl == 0) ? 1 : ((pl > 8) ? 8 : pl);
      case (ph)
        1:       rl = 8;
        3:       rl = 0;
        5:       rl = $urandom_range(9, 15);
        default: rl = $urandom_range(0, 8);
      endcase
      pw = {$urandom, $urandom};
      for (int j = 0; j < pe; j++) pw[8*j +: 8] = alpha[$urandom_range(0, 2)];
      write_reg(spr_pkg::REG_PATTERN_BYTES, pw);
      write_reg(spr_pkg::REG_PATTERN_LENGTH, ({$urandom, $urandom} & ~64'hF) | 64'(pl));
      write_reg(spr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      write_reg(spr_pkg::REG_REPLACEMENT_LENGTH,
                ({$urandom, $urandom} & ~64'hF) | 64'(rl));
      if (ph == 2) hold_asked++;   // receiver blocks while input keeps coming

      n = $urandom_range(20, 24);
      k = 0;
      while (k < n) begin
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
          clen = pe;
          for (int j = 0; j < pe; j++) chunk[j] = pw[8*j +: 8];
          if (sel == 4) chunk[$urandom_range(0, pe-1)] = alpha[$urandom_range(0, 2)];
        end else begin
          clen = 1;
          chunk[0] = (sel < 8) ? alpha[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
        end
        for (int j = 0; j < clen && k < n; j++) begin
          fin = (k == n - 1) || ($urandom_range(0, 13) == 0);
          send_byte(chunk[j], fin);
          queue_predicted();
          k++;
          if (ph == 4 && k == 10) wait_drained();
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_out_bytes.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d input bytes in %0d streams over %0d register writes,",
             bytes_sent, streams_done, regs_written);
    $display("with %0d output bytes checked against the window predictor.", results_seen);
    if (err_cnt == 0) begin
      $display("stream_pattern_replace_top test passed");
    end else begin
      $display("stream_pattern_replace_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/spr_pkg.sv
hw/rtl/spr_front.sv
hw/rtl/spr_queue.sv
hw/rtl/spr_back.sv
hw/rtl/stream_pattern_replace_top.sv
hw/rtl/spr_checker.sv
test/stream_pattern_replace_top_tb.sv
